/* rtl/apwr_pkg.sv */
// Shared types, widths and codes for the activity power estimator.
// No dependencies; every other file in rtl/ imports this package.
package apwr_pkg;

  // Accumulator width and derived widths.
  localparam int TimeWidth = 32;
  localparam int AmountW   = 32;
  localparam int IntvW     = 22;
  localparam int CurW      = 16;
  localparam int SumW      = ((TimeWidth > AmountW) ? TimeWidth : AmountW) + 1;
  localparam int TotW      = TimeWidth + 2;
  localparam int ProdW     = TimeWidth + CurW;
  localparam int AccW      = ProdW + 2;
  localparam int EProdW    = CurW + IntvW;
  localparam int EDvdW     = EProdW + 4;
  localparam int DvdW      = AccW;
  localparam int EnergyW   = 25;

  // Divider: average only, which never exceeds the largest current.
  localparam int DivSteps  = CurW;
  localparam int DivCntW   = $clog2(DivSteps + 1);

  // Energy: 11 * avg * interval / 120000, with 120000 = 2^6 * 1875.
  // The shifted value is below 2^36; times ceil(2^47 / 1875), then >> 47.
  localparam int EShift    = 6;
  localparam int EYW       = EDvdW - EShift;
  localparam int EHalfW    = EYW / 2;
  localparam int RcpW      = 37;
  localparam int RcpShift  = 47;
  localparam logic [RcpW-1:0] RcpMul = 37'd75059993790;
  localparam int RcpPW     = EHalfW + RcpW;
  localparam int RcpSumW   = EYW + RcpW;

  // Weighted sum: one product per lane plus a drain step.
  localparam int NumLanes  = 4;
  localparam int MacSteps  = NumLanes + 1;
  localparam int MacCntW   = $clog2(MacSteps);

  // Accumulator lanes, ordered like the add function codes.
  localparam logic [1:0] LaneCpu   = 2'd0;
  localparam logic [1:0] LaneRadio = 2'd1;
  localparam logic [1:0] LaneIdle  = 2'd2;
  localparam logic [1:0] LaneSleep = 2'd3;

  // Function codes.
  localparam logic [2:0] FuncAddCpu   = 3'd0;
  localparam logic [2:0] FuncAddRadio = 3'd1;
  localparam logic [2:0] FuncAddIdle  = 3'd2;
  localparam logic [2:0] FuncAddSleep = 3'd3;
  localparam logic [2:0] FuncSubIdle  = 3'd4;
  localparam logic [2:0] FuncTick     = 3'd5;
  localparam logic [2:0] FuncRestart  = 3'd6;

  // Configuration register indexes.
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = IntvW;
  localparam logic [CfgIdxW-1:0] CfgInterval = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgIdleCur  = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgCpuCur   = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgRadioCur = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgSleepCur = 3'd4;

  // Configuration reset values.
  localparam logic [IntvW-1:0] IntervalRst = IntvW'(5000);
  localparam logic [CurW-1:0]  IdleCurRst  = CurW'(7000);
  localparam logic [CurW-1:0]  CpuCurRst   = CurW'(9000);
  localparam logic [CurW-1:0]  RadioCurRst = CurW'(15000);
  localparam logic [CurW-1:0]  SleepCurRst = CurW'(1500);

  typedef struct packed {
    logic [2:0]         func;
    logic [AmountW-1:0] amount_ms;
  } in_beat_t;

  typedef struct packed {
    logic               report_status;
    logic [CurW-1:0]    avg_current;
    logic [EnergyW-1:0] energy;
  } out_beat_t;

  // Controller to datapath.
  typedef struct packed {
    logic               accept;
    logic               capture;
    logic               mac_en;
    logic [MacCntW-1:0] mac_idx;
    logic               div_start;
    logic               avg_load;
    logic               mul_e;
    logic               rcp_lo;
    logic               rcp_hi;
    logic               out_load;
    logic               out_nodata;
  } dp_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic report_hit;
    logic total_zero;
    logic div_done;
    logic out_free;
  } dp_status_t;

  typedef enum logic [7:0] {
    ST_IDLE = 8'b0000_0001,
    ST_MAC  = 8'b0000_0010,
    ST_LDA  = 8'b0000_0100,
    ST_DIVA = 8'b0000_1000,
    ST_MULE = 8'b0001_0000,
    ST_RCPL = 8'b0010_0000,
    ST_RCPH = 8'b0100_0000,
    ST_OUT  = 8'b1000_0000
  } state_e;

endpackage

/* rtl/apwr_div.sv */
// Restoring divider, one quotient bit per cycle, DivSteps bits.
// Depends on apwr_pkg.
module apwr_div (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [apwr_pkg::DvdW-1:0] dividend_i,
  input  logic [apwr_pkg::TotW-1:0] divisor_i,
  output logic                     done_o,
  output logic [apwr_pkg::DivSteps-1:0] quot_o
);
  import apwr_pkg::*;

  logic [TotW-1:0]     rem_q, rem_d;
  logic [TotW-1:0]     dsr_q;
  logic [DivSteps-1:0] dvd_q, dvd_d;
  logic [DivCntW-1:0]  cnt_q;
  logic                busy_q, done_q;
  logic [TotW:0]       trial;
  logic [TotW:0]       diff;
  logic                qbit;

  // dividend >> DivSteps is below the divisor, so the remainder never grows past it
  always_comb begin
    trial = {rem_q, dvd_q[DivSteps-1]};
    diff  = trial - {1'b0, dsr_q};
    qbit  = (trial >= {1'b0, dsr_q});
    rem_d = qbit ? diff[TotW-1:0] : trial[TotW-1:0];
    dvd_d = {dvd_q[DivSteps-2:0], qbit};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        if (cnt_q == DivCntW'(DivSteps - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
        cnt_q <= cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= TotW'(dividend_i >> DivSteps);
      dvd_q <= dividend_i[DivSteps-1:0];
      dsr_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      dvd_q <= dvd_d;
    end
  end

  assign done_o = done_q;
  assign quot_o = dvd_q;

endmodule

/* rtl/apwr_dp.sv */
// Datapath: config registers, accumulators, weighted sum, divider, energy, output register.
// Depends on apwr_pkg and apwr_div.
module apwr_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  apwr_pkg::in_beat_t            in_beat_i,
  input  logic                          cfg_we_i,
  input  logic [apwr_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [apwr_pkg::CfgDataW-1:0] cfg_data_i,
  input  apwr_pkg::dp_cmd_t             cmd_i,
  output apwr_pkg::dp_status_t          status_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output apwr_pkg::out_beat_t           out_beat_o
);
  import apwr_pkg::*;

  localparam logic [TimeWidth-1:0] TimeMax = '1;

  logic [IntvW-1:0]     interval_q;
  logic [CurW-1:0]      cur_q [NumLanes];
  logic [TimeWidth-1:0] times_q [NumLanes];
  logic [TimeWidth-1:0] times_d [NumLanes];
  logic [IntvW-1:0]     elapsed_q, elapsed_d;

  logic [TotW-1:0]      total_sum, total_q;
  logic [ProdW-1:0]     prod_q;
  logic [AccW-1:0]      acc_q;
  logic [CurW-1:0]      avg_q;
  logic [EProdW-1:0]    eprod_q;
  logic [EDvdW-1:0]     edvd;
  logic [EYW-1:0]       ey;
  logic [EHalfW-1:0]    rcp_op;
  logic [RcpPW-1:0]     rcp_prod, plo_q, phi_q;
  logic [RcpSumW-1:0]   rcp_sum;
  logic                 div_done;
  logic [DivSteps-1:0]  quot;

  logic                 out_valid_q;
  out_beat_t            out_q;

  logic [SumW-1:0]      add_sum;
  logic [SumW-1:0]      idle_ext, amt_ext;
  logic [IntvW:0]       tick_next;
  logic                 report_hit;
  logic [1:0]           lane;
  logic [1:0]           mac_lane;

  assign lane     = in_beat_i.func[1:0];
  assign mac_lane = cmd_i.mac_idx[1:0];

  always_comb begin
    times_d   = times_q;
    elapsed_d = elapsed_q;
    add_sum   = SumW'(times_q[lane]) + SumW'(in_beat_i.amount_ms);
    idle_ext  = SumW'(times_q[LaneIdle]);
    amt_ext   = SumW'(in_beat_i.amount_ms);
    tick_next = {1'b0, elapsed_q} + 1'b1;
    report_hit = (in_beat_i.func == FuncTick) && (tick_next >= {1'b0, interval_q});
    if (cmd_i.accept) begin
      case (in_beat_i.func)
        FuncAddCpu, FuncAddRadio, FuncAddIdle, FuncAddSleep: begin
          times_d[lane] = (add_sum > SumW'(TimeMax)) ? TimeMax : add_sum[TimeWidth-1:0];
        end
        FuncSubIdle: begin
          if (amt_ext != '0) begin
            times_d[LaneIdle] = (idle_ext > amt_ext) ?
                                TimeWidth'(idle_ext - amt_ext) : '0;
          end
        end
        FuncTick: begin
          elapsed_d = report_hit ? '0 : tick_next[IntvW-1:0];
        end
        FuncRestart: begin
          for (int i = 0; i < NumLanes; i++) times_d[i] = '0;
          elapsed_d = '0;
        end
        default: ;
      endcase
    end
    // accumulators clear once a report is written out
    if (cmd_i.out_load) begin
      for (int i = 0; i < NumLanes; i++) times_d[i] = '0;
    end
  end

  always_comb begin
    total_sum = TotW'(times_q[LaneCpu]) + TotW'(times_q[LaneRadio])
              + TotW'(times_q[LaneIdle]) + TotW'(times_q[LaneSleep]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      interval_q         <= IntervalRst;
      cur_q[LaneIdle]    <= IdleCurRst;
      cur_q[LaneCpu]     <= CpuCurRst;
      cur_q[LaneRadio]   <= RadioCurRst;
      cur_q[LaneSleep]   <= SleepCurRst;
      for (int i = 0; i < NumLanes; i++) times_q[i] <= '0;
      elapsed_q          <= '0;
      out_valid_q        <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CfgInterval: interval_q       <= cfg_data_i;
          CfgIdleCur:  cur_q[LaneIdle]  <= cfg_data_i[CurW-1:0];
          CfgCpuCur:   cur_q[LaneCpu]   <= cfg_data_i[CurW-1:0];
          CfgRadioCur: cur_q[LaneRadio] <= cfg_data_i[CurW-1:0];
          CfgSleepCur: cur_q[LaneSleep] <= cfg_data_i[CurW-1:0];
          default: ;
        endcase
      end
      times_q   <= times_d;
      elapsed_q <= elapsed_d;
      if (cmd_i.out_load) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  // weighted sum: product registered, added to the accumulator in the next cycle
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      total_q <= total_sum;
      acc_q   <= '0;
      prod_q  <= '0;
    end else if (cmd_i.mac_en) begin
      acc_q  <= acc_q + AccW'(prod_q);
      prod_q <= (cmd_i.mac_idx < MacCntW'(NumLanes)) ?
                ProdW'(times_q[mac_lane]) * ProdW'(cur_q[mac_lane]) : '0;
    end
    if (cmd_i.avg_load) avg_q <= quot[CurW-1:0];
    if (cmd_i.mul_e) eprod_q <= EProdW'(avg_q) * EProdW'(interval_q);
    if (cmd_i.rcp_lo) plo_q <= rcp_prod;
    if (cmd_i.rcp_hi) phi_q <= rcp_prod;
    if (cmd_i.out_load) begin
      out_q.report_status <= cmd_i.out_nodata;
      out_q.avg_current   <= cmd_i.out_nodata ? '0 : avg_q;
      out_q.energy        <= cmd_i.out_nodata ? '0 : rcp_sum[RcpShift +: EnergyW];
    end
  end

  // times 11 as shift and add
  assign edvd = (EDvdW'(eprod_q) << 3) + (EDvdW'(eprod_q) << 1) + EDvdW'(eprod_q);

  // divide by 120000: drop the 2^6 factor, then reciprocal of 1875 in two halves
  assign ey       = edvd[EDvdW-1:EShift];
  assign rcp_op   = cmd_i.rcp_hi ? ey[EYW-1:EHalfW] : ey[EHalfW-1:0];
  assign rcp_prod = RcpPW'(rcp_op) * RcpPW'(RcpMul);
  assign rcp_sum  = RcpSumW'(plo_q) + (RcpSumW'(phi_q) << EHalfW);

  apwr_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (acc_q),
    .divisor_i  (total_q),
    .done_o     (div_done),
    .quot_o     (quot)
  );

  assign status_o.report_hit = report_hit;
  assign status_o.total_zero = (total_sum == '0);
  assign status_o.div_done   = div_done;
  assign status_o.out_free   = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_beat_o  = out_q;

endmodule

/* rtl/apwr_ctrl.sv */
// Controller: sequences accept, weighted sum, division, energy and the report write.
// Depends on apwr_pkg.
module apwr_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  apwr_pkg::dp_status_t status_i,
  output apwr_pkg::dp_cmd_t    cmd_o
);
  import apwr_pkg::*;

  state_e             state_q, state_d;
  logic [MacCntW-1:0] mac_cnt_q, mac_cnt_d;
  logic               nodata_q, nodata_d;

  always_comb begin
    state_d   = state_q;
    mac_cnt_d = mac_cnt_q;
    nodata_d  = nodata_q;
    cmd_o     = '0;
    cmd_o.mac_idx    = mac_cnt_q;
    cmd_o.out_nodata = nodata_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          if (status_i.report_hit) begin
            if (status_i.total_zero) begin
              nodata_d = 1'b1;
              state_d  = ST_OUT;
            end else begin
              cmd_o.capture = 1'b1;
              mac_cnt_d     = '0;
              state_d       = ST_MAC;
            end
          end
        end
      end
      ST_MAC: begin
        cmd_o.mac_en = 1'b1;
        mac_cnt_d    = mac_cnt_q + 1'b1;
        if (mac_cnt_q == MacCntW'(MacSteps - 1)) state_d = ST_LDA;
      end
      ST_LDA: begin
        cmd_o.div_start = 1'b1;
        state_d         = ST_DIVA;
      end
      ST_DIVA: begin
        if (status_i.div_done) begin
          cmd_o.avg_load = 1'b1;
          state_d        = ST_MULE;
        end
      end
      ST_MULE: begin
        cmd_o.mul_e = 1'b1;
        state_d     = ST_RCPL;
      end
      ST_RCPL: begin
        cmd_o.rcp_lo = 1'b1;
        state_d      = ST_RCPH;
      end
      ST_RCPH: begin
        cmd_o.rcp_hi = 1'b1;
        state_d      = ST_OUT;
      end
      ST_OUT: begin
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          nodata_d       = 1'b0;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      mac_cnt_q <= '0;
      nodata_q  <= 1'b0;
    end else begin
      state_q   <= state_d;
      mac_cnt_q <= mac_cnt_d;
      nodata_q  <= nodata_d;
    end
  end

  assign in_ready_o = (state_q == ST_IDLE);

endmodule

/* rtl/activity_power_estimator.sv */
// Activity power estimator: accumulators, report sequencer and output register.
// Adds, subtracts, restarts and non-reporting ticks are taken back to back.
// A reporting tick runs the weighted sum, average division, energy product,
// reciprocal multiply in two halves and the output load, which waits for a free
// output register; the next beat is taken after the load. An empty interval goes straight to the output load.
// Reset (async, low): accumulators and tick count zero, registers to defaults.
module activity_power_estimator (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  apwr_pkg::in_beat_t            in_beat_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output apwr_pkg::out_beat_t           out_beat_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [apwr_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [apwr_pkg::CfgDataW-1:0] cfg_data_i
);
  import apwr_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;
  logic       cfg_we;

  // Config writes are taken on any cycle; the user must ensure they are only issued while idle (unchecked).
  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i;

  // Sequencer: accepts beats while idle, even if a report beat is still
  // waiting downstream; the output register decouples the two sides.
  apwr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // Datapath: accumulators, weighted sum, divider, report register.
  apwr_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_beat_i   (in_beat_i),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_beat_o  (out_beat_o)
  );

endmodule

/* tb/apwr_checker.sv */
// Scoreboard for the activity power estimator: mirrors the accumulators and
// settings, predicts each report beat and compares it field by field.
// Depends on apwr_pkg for beat types, function codes and register indexes.
module apwr_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic                          in_ready_i,
  input  apwr_pkg::in_beat_t            in_beat_i,
  input  logic                          out_valid_i,
  input  logic                          out_ready_i,
  input  apwr_pkg::out_beat_t           out_beat_i,
  input  logic                          cfg_valid_i,
  input  logic                          cfg_ready_i,
  input  logic [apwr_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [apwr_pkg::CfgDataW-1:0] cfg_data_i,
  output int                            pending_o,
  output int                            fail_count_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import apwr_pkg::*;

  localparam logic [63:0] EnergyMul = 64'd11;
  localparam logic [63:0] EnergyDiv = 64'd120000;

  // Mirrored settings and accumulators.
  logic [IntvW-1:0]     interval_ms;
  logic [CurW-1:0]      idle_cur, cpu_cur, radio_cur, sleep_cur;
  logic [TimeWidth-1:0] cpu_ms, radio_ms, idle_ms, sleep_ms;
  logic [IntvW-1:0]     ms_ticks;

  out_beat_t reports_due[$];
  out_beat_t want, rep;
  logic [63:0] wsum, total_ms, avg_full, e_full;
  int errors = 0;

  assign fail_count_o = errors;

  function automatic logic [TimeWidth-1:0] sat_sum(input logic [TimeWidth-1:0] acc,
                                                   input logic [AmountW-1:0] amt);
    logic [TimeWidth:0] s;
    s = {1'b0, acc} + (TimeWidth + 1)'(amt);
    return s[TimeWidth] ? '1 : s[TimeWidth-1:0];
  endfunction

  task automatic log_mismatch(input string what);
    errors++;
    $display("[%0t] MISMATCH #%0d: %s", $realtime, errors, what);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      interval_ms = IntervalRst;
      idle_cur    = IdleCurRst;
      cpu_cur     = CpuCurRst;
      radio_cur   = RadioCurRst;
      sleep_cur   = SleepCurRst;
      cpu_ms      = '0;
      radio_ms    = '0;
      idle_ms     = '0;
      sleep_ms    = '0;
      ms_ticks    = '0;
      reports_due.delete();
      pending_o <= 0;
    end else begin
      // Output side first: a beat leaving now belongs to an older tick.
      if (out_valid_i && out_ready_i) begin
        if (reports_due.size() == 0) begin
          log_mismatch($sformatf("report beat with nothing outstanding: %p", out_beat_i));
        end else begin
          want = reports_due.pop_front();
          if (out_beat_i.report_status !== want.report_status)
            log_mismatch($sformatf("report_status got %0d want %0d",
                                   out_beat_i.report_status, want.report_status));
          if (out_beat_i.avg_current !== want.avg_current)
            log_mismatch($sformatf("avg_current got %0d want %0d",
                                   out_beat_i.avg_current, want.avg_current));
          if (out_beat_i.energy !== want.energy)
            log_mismatch($sformatf("energy got %0d want %0d",
                                   out_beat_i.energy, want.energy));
        end
      end

      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CfgInterval: interval_ms = cfg_data_i[IntvW-1:0];
          CfgIdleCur:  idle_cur    = cfg_data_i[CurW-1:0];
          CfgCpuCur:   cpu_cur     = cfg_data_i[CurW-1:0];
          CfgRadioCur: radio_cur   = cfg_data_i[CurW-1:0];
          CfgSleepCur: sleep_cur   = cfg_data_i[CurW-1:0];
          default: ;
        endcase
      end

      if (in_valid_i && in_ready_i) begin
        case (in_beat_i.func)
          FuncAddCpu:   cpu_ms   = sat_sum(cpu_ms, in_beat_i.amount_ms);
          FuncAddRadio: radio_ms = sat_sum(radio_ms, in_beat_i.amount_ms);
          FuncAddIdle:  idle_ms  = sat_sum(idle_ms, in_beat_i.amount_ms);
          FuncAddSleep: sleep_ms = sat_sum(sleep_ms, in_beat_i.amount_ms);
          // floor at zero; subtracting nothing leaves idle time alone
          FuncSubIdle:  idle_ms  = (idle_ms > in_beat_i.amount_ms) ?
                                   idle_ms - in_beat_i.amount_ms : '0;
          FuncRestart: begin
            cpu_ms   = '0;
            radio_ms = '0;
            idle_ms  = '0;
            sleep_ms = '0;
            ms_ticks = '0;
          end
          FuncTick: begin
            if (32'(ms_ticks) + 32'd1 < 32'(interval_ms)) begin
              ms_ticks = ms_ticks + 1'b1;
            end else begin
              ms_ticks = '0;
              total_ms = 64'(cpu_ms) + 64'(radio_ms) + 64'(idle_ms) + 64'(sleep_ms);
              if (total_ms == 0) begin
                // empty interval: flagged, values forced to zero
                rep.report_status = 1'b1;
                rep.avg_current   = '0;
                rep.energy        = '0;
              end else begin
                wsum = 64'(idle_ms) * 64'(idle_cur) + 64'(cpu_ms) * 64'(cpu_cur)
                     + 64'(radio_ms) * 64'(radio_cur) + 64'(sleep_ms) * 64'(sleep_cur);
                avg_full = wsum / total_ms;
                e_full = (64'(avg_full[CurW-1:0]) * 64'(interval_ms) * EnergyMul)
                         / EnergyDiv;
                rep.report_status = 1'b0;
                rep.avg_current   = avg_full[CurW-1:0];
                rep.energy        = e_full[EnergyW-1:0];
                cpu_ms   = '0;
                radio_ms = '0;
                idle_ms  = '0;
                sleep_ms = '0;
              end
              reports_due.push_back(rep);
            end
          end
          default: ;  // unused code, dropped by the block
        endcase
      end

      pending_o <= reports_due.size();
    end
  end

endmodule

/* tb/tb_activity_power_estimator.sv */
// Top-level bench for activity_power_estimator: clock, reset, stimulus and verdict.
// Directed corner cases first, then randomized phases under varying settings.
// Depends on apwr_pkg, the RTL top and apwr_checker (which does all prediction).
module tb_activity_power_estimator;
  timeunit 1ns;
  timeprecision 1ps;
  import apwr_pkg::*;

  // Code 7 has no meaning; the block must swallow it without a beat.
  localparam logic [2:0] FuncUnused = 3'd7;

  localparam int RandPhases    = 6;
  localparam int ItemsPerPhase = 305;
  localparam int HoldPhase     = 1;     // phase with the long output hold-off
  localparam int HoldCycles    = 400;
  localparam int SettleCycles  = 100;   // longer than one full report sequence
  localparam int CycleLimit    = 1_000_000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                in_valid = 1'b0;
  logic                in_ready;
  in_beat_t            in_beat = '0;
  logic                out_valid;
  logic                out_ready = 1'b1;
  out_beat_t           out_beat;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data = '0;

  int pending;
  int fails;
  int cycles = 0;

  // quiet: last stretch of the run with no idling on either side.
  // hold_req: asks the receiver for one long hold-off.
  logic quiet = 1'b0;
  logic hold_req = 1'b0;

  always #1 clk_i = ~clk_i;

  activity_power_estimator dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_beat_i   (in_beat),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_beat_o  (out_beat),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  apwr_checker u_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .in_beat_i    (in_beat),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .out_beat_i   (out_beat),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_i  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .pending_o    (pending),
    .fail_count_o (fails)
  );

  // Watchdog: generous bound on the whole run, hold-off and settling included.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Receiver: short random stalls, one long hold-off on request, none when quiet.
  initial begin : rx_side
    logic held;
    held = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req && !held) begin
        held = 1'b1;
        out_ready <= 1'b0;
        // sender keeps pushing meanwhile; the block backs up to its input
        repeat (HoldCycles) @(posedge clk_i);
        out_ready <= 1'b1;
      end else if (!quiet && $urandom_range(4) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk_i);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // One input beat. Valid stays up across back-to-back beats; an idle burst
  // may come first unless the run is in its quiet stretch.
  task automatic send_item(input logic [2:0] f, input logic [AmountW-1:0] amt);
    in_beat_t beat;
    beat.func      = f;
    beat.amount_ms = amt;
    if (!quiet && $urandom_range(3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_beat  <= beat;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
  endtask

  // Drop valid, wait for every outstanding report, then let the block go idle.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Writes all five registers; unused upper data bits carry junk on purpose.
  task automatic write_settings(input logic [IntvW-1:0] intv,
                                input logic [CurW-1:0] idle_c, cpu_c, radio_c, sleep_c);
    logic [CfgIdxW-1:0]  idx [5];
    logic [CfgDataW-1:0] val [5];
    idx = '{CfgInterval, CfgIdleCur, CfgCpuCur, CfgRadioCur, CfgSleepCur};
    val = '{intv,
            {6'($urandom), idle_c}, {6'($urandom), cpu_c},
            {6'($urandom), radio_c}, {6'($urandom), sleep_c}};
    for (int i = 0; i < 5; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= val[i];
      @(posedge clk_i);
      while (!cfg_ready) @(posedge clk_i);
    end
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [CurW-1:0] pick_current();
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      default: return CurW'($urandom);
    endcase
  endfunction

  initial begin : stimulus
    logic [2:0]         f;
    logic [AmountW-1:0] amt;
    logic [IntvW-1:0]   intv;
    int                 r;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    settle();

    // --- Directed: interval 2, every current at full scale.
    write_settings(IntvW'(2), '1, '1, '1, '1);
    // All four lanes saturate; a one on top of a full cpu lane must stick.
    send_item(FuncAddCpu,   '1);
    send_item(FuncAddCpu,   AmountW'(1));
    send_item(FuncAddRadio, '1);
    send_item(FuncAddIdle,  '1);
    send_item(FuncAddSleep, '1);
    send_item(FuncSubIdle,  '0);          // subtracting nothing
    send_item(FuncTick,     '0);
    send_item(FuncTick,     '1);          // full-scale average report
    // Idle subtraction, then clamp at zero; sleep keeps the interval non-empty.
    send_item(FuncAddIdle,  AmountW'(100));
    send_item(FuncSubIdle,  AmountW'(30));
    send_item(FuncSubIdle,  AmountW'(1000));
    send_item(FuncAddSleep, AmountW'(7));
    send_item(FuncTick,     '0);
    send_item(FuncTick,     '0);
    // Restart mid-interval drops both time and tick count; code 7 is ignored.
    send_item(FuncAddRadio, AmountW'(50));
    send_item(FuncTick,     '0);
    send_item(FuncRestart,  '1);
    send_item(FuncUnused,   '1);
    send_item(FuncTick,     '0);
    send_item(FuncTick,     '0);          // nothing logged: empty report
    settle();

    // --- Interval zero reports on every tick; zero and full currents mixed.
    write_settings('0, '0, '0, '1, CurW'(1));
    send_item(FuncAddCpu,   AmountW'(3));
    send_item(FuncAddRadio, AmountW'(1));
    send_item(FuncTick,     '0);
    send_item(FuncTick,     '0);
    settle();

    // --- Largest interval, then lowered under the tick count already reached.
    write_settings('1, pick_current(), pick_current(), pick_current(), pick_current());
    send_item(FuncAddSleep, AmountW'(9));
    send_item(FuncTick,     '0);
    send_item(FuncTick,     '0);
    send_item(FuncTick,     '0);
    settle();
    write_settings(IntvW'(2), pick_current(), pick_current(), pick_current(),
                   pick_current());
    send_item(FuncTick,     '0);          // count already past interval: reports

    // --- Random phases, each under fresh settings.
    for (int ph = 0; ph < RandPhases; ph++) begin
      settle();
      if (ph == HoldPhase) begin
        intv = '0;                        // every tick reports: fills up fast
        hold_req <= 1'b1;
      end else begin
        case ($urandom_range(5))
          0:       intv = '0;
          1:       intv = IntvW'(1);
          default: intv = IntvW'($urandom_range(2, 24));
        endcase
      end
      write_settings(intv, pick_current(), pick_current(), pick_current(), pick_current());
      if (ph == RandPhases - 1) quiet <= 1'b1;

      for (int n = 0; n < ItemsPerPhase; n++) begin
        r = $urandom_range(99);
        if (r < 44)      f = FuncAddCpu + 3'($urandom_range(3));
        else if (r < 54) f = FuncSubIdle;
        else if (r < 90) f = FuncTick;
        else if (r < 95) f = FuncRestart;
        else             f = FuncUnused;
        // Mostly modest amounts so averages vary; some extremes and full range.
        case ($urandom_range(9))
          0:       amt = '0;
          1:       amt = '1;
          2:       amt = AmountW'($urandom);
          3, 4:    amt = AmountW'($urandom_range(65535));
          default: amt = AmountW'($urandom_range(1000));
        endcase
        send_item(f, amt);
      end
    end

    settle();
    if (fails == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
